/* rtl/core/hwd_pkg.sv */
// shared types, constants and lane helpers of the pixel hit word decoder
package hwd_pkg;

    localparam int ROW_COUNT     = 114;
    localparam int COL_COUNT     = 24;
    localparam int HITS_PER_WORD = 16;

    localparam int ROW_W  = 7;
    localparam int COL_W  = 5;
    localparam int FC_W   = 12;
    localparam int TRIG_W = 31;
    localparam int KIND_W = 3;
    localparam int IDX_W  = 8;
    localparam int LANE_W = $clog2(HITS_PER_WORD);

    // base pixel of the first data word: top = ROW_COUNT * COL_COUNT - 1
    localparam logic [ROW_W-1:0] TOP_ROW = ROW_W'((ROW_COUNT * COL_COUNT - 1) % ROW_COUNT);
    localparam logic [COL_W-1:0] TOP_COL = COL_W'((ROW_COUNT * COL_COUNT - 1) / ROW_COUNT);
    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    localparam logic [3:0] HDR_NIBBLE = 4'h6;

    localparam logic [KIND_W-1:0] KIND_TRIG     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HIT      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TRIG_ERR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HDR_ERR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_lane_res;

    typedef struct packed {
        logic [HITS_PER_WORD-1:0] mask;
        logic [FC_W-1:0]          fc;
        logic [TRIG_W-1:0]        trig;
    } t_load;

    // pixel offset below the word's base pixel for result slot j
    // even slots: byte1 bit k -> 7 - k, odd slots: byte0 bit k -> 15 - k
    function automatic logic [LANE_W-1:0] lane_offset(input int j);
        if (j % 2 == 0) begin
            return LANE_W'(HITS_PER_WORD / 2 - 1 - j / 2);
        end
        return LANE_W'(HITS_PER_WORD - 1 - j / 2);
    endfunction

    // word bit that holds the active-low hit of result slot j
    function automatic int lane_bit(input int j);
        if (j % 2 == 0) begin
            return HITS_PER_WORD / 2 + j / 2;
        end
        return j / 2;
    endfunction

endpackage

/* rtl/core/pixel_hit_word_decoder_top.sv */
// pixel hit word decoder: block state, sixteen mapping lanes and the result merge
// a word's results pass through the result buffer and then the output register
// throughput: one result per cycle while the output is not stalled; a word leaves 0 to 16 results
// the merge stage, which sends one buffered lane result per cycle when not stalled, sets that rate
// a new word is taken when the buffer is empty or its last result moves to the output register
// reset (synchronous, active low) closes any open block and drops all pending results
module pixel_hit_word_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // word[31:0]
    input  logic [0:0]  i_s_axis_tuser,   // block_start[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // row[6:0] col[11:7] frame_count[23:12]
                                          // trig_num[54:24] zero[55]
    output logic [2:0]  o_m_axis_tuser,   // kind[2:0]
    output logic        o_m_axis_tlast
);
    import hwd_pkg::*;

    // block state
    logic [IDX_W-1:0] r_word_idx, n_word_idx;
    logic             r_aborted, n_aborted;
    // linear position of the current data word's base pixel, kept incrementally
    logic [ROW_W-1:0] r_base_row, n_base_row;
    logic [COL_W-1:0] r_base_col, n_base_col;
    logic             r_base_neg, n_base_neg;   // base pixel has run past the array

    logic             in_xfer;
    logic [31:0]      word;
    logic             block_start;
    logic             hdr_ok;

    t_lane_res [HITS_PER_WORD-1:0] lane_res;
    t_lane_res [HITS_PER_WORD-1:0] load_ent;
    t_load                         load_info;
    logic                          load;
    logic                          load_ready;

    t_lane_res                     out_res;
    logic [FC_W-1:0]               out_fc;
    logic [TRIG_W-1:0]             out_trig;

    assign word        = i_s_axis_tdata;
    assign block_start = i_s_axis_tuser[0];
    assign in_xfer     = i_s_axis_tvalid && load_ready;
    assign hdr_ok      = (word[31:28] == HDR_NIBBLE);
    assign o_s_axis_tready = load_ready;

    // one lane per hit bit, each one at a fixed offset below the base pixel
    for (genvar j = 0; j < HITS_PER_WORD; j++) begin : g_lane
        hwd_lane u_lane (
            .i_base_row (r_base_row),
            .i_base_col (r_base_col),
            .i_base_neg (r_base_neg),
            .i_offset   (lane_offset(j)),
            .o_res      (lane_res[j])
        );
    end

    // what a word leaves in the result buffer, and how it moves the block state
    always_comb begin
        n_word_idx = r_word_idx;
        n_aborted  = r_aborted;
        n_base_row = r_base_row;
        n_base_col = r_base_col;
        n_base_neg = r_base_neg;
        load_ent   = lane_res;
        load_info.mask = '0;
        load_info.fc   = '0;
        load_info.trig = '0;

        priority if (block_start) begin
            // trigger word: one result, good or bad
            load_info.mask    = HITS_PER_WORD'(1);
            load_info.trig    = word[TRIG_W-1:0];
            load_ent[0].row   = '0;
            load_ent[0].col   = '0;
            if (word[31]) begin
                load_ent[0].kind = KIND_TRIG;
                n_aborted  = 1'b0;
                n_word_idx = IDX_W'(1);
                n_base_row = TOP_ROW;
                n_base_col = TOP_COL;
                n_base_neg = 1'b0;
            end else begin
                load_ent[0].kind = KIND_TRIG_ERR;
                n_aborted  = 1'b1;
                n_word_idx = '0;
            end
        end else if (r_aborted || (r_word_idx == '0)) begin
            // outside a block: word dropped
            load_info.mask = '0;
        end else if (!hdr_ok) begin
            load_info.mask   = HITS_PER_WORD'(1);
            load_ent[0].kind = KIND_HDR_ERR;
            load_ent[0].row  = '0;
            load_ent[0].col  = '0;
            n_aborted        = 1'b1;
        end else begin
            // data word: active-low hit bits select lanes
            load_info.fc = word[16 +: FC_W];
            for (int j = 0; j < HITS_PER_WORD; j++) begin
                load_info.mask[j] = !word[lane_bit(j)];
            end
            // the index saturates and the base pixel stays with it
            if (r_word_idx != IDX_MAX) begin
                n_word_idx = r_word_idx + IDX_W'(1);
                if (r_base_row >= ROW_W'(HITS_PER_WORD)) begin
                    n_base_row = r_base_row - ROW_W'(HITS_PER_WORD);
                end else begin
                    n_base_row = ROW_W'((ROW_W+1)'(r_base_row) + (ROW_W+1)'(ROW_COUNT)
                               - (ROW_W+1)'(HITS_PER_WORD));
                    if (r_base_col == '0) begin
                        n_base_neg = 1'b1;
                    end else begin
                        n_base_col = r_base_col - COL_W'(1);
                    end
                end
            end
        end
    end

    assign load = in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_idx <= '0;
            r_aborted  <= 1'b0;
            r_base_row <= TOP_ROW;
            r_base_col <= TOP_COL;
            r_base_neg <= 1'b0;
        end else if (in_xfer) begin
            r_word_idx <= n_word_idx;
            r_aborted  <= n_aborted;
            r_base_row <= n_base_row;
            r_base_col <= n_base_col;
            r_base_neg <= n_base_neg;
        end
    end

    // buffer of lane results and the output register
    hwd_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_load_info  (load_info),
        .i_lanes      (load_ent),
        .o_load_ready (load_ready),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_res        (out_res),
        .o_fc         (out_fc),
        .o_trig       (out_trig),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_trig, out_fc, out_res.col, out_res.row};
    assign o_m_axis_tuser = out_res.kind;

endmodule

/* rtl/core/hwd_lane.sv */
// one mapping lane: offset below base pixel to serpentine row and column
module hwd_lane (
    input  logic [hwd_pkg::ROW_W-1:0]  i_base_row,
    input  logic [hwd_pkg::COL_W-1:0]  i_base_col,
    input  logic                       i_base_neg,
    input  logic [hwd_pkg::LANE_W-1:0] i_offset,
    output hwd_pkg::t_lane_res         o_res
);
    import hwd_pkg::*;

    logic             borrow;
    logic [ROW_W:0]   row_sum;
    logic [ROW_W-1:0] row_lin;
    logic [COL_W-1:0] col_lin;
    logic             past_end;
    logic [ROW_W-1:0] row_mir;

    assign borrow = {1'b0, i_base_row} < (ROW_W+1)'(i_offset);

    always_comb begin
        if (borrow) begin
            row_sum = (ROW_W+1)'(i_base_row) + (ROW_W+1)'(ROW_COUNT)
                    - (ROW_W+1)'(i_offset);
            col_lin = i_base_col - COL_W'(1);
        end else begin
            row_sum = (ROW_W+1)'(i_base_row) - (ROW_W+1)'(i_offset);
            col_lin = i_base_col;
        end
    end

    assign row_lin  = row_sum[ROW_W-1:0];
    assign past_end = i_base_neg || (borrow && (i_base_col == '0));
    assign row_mir  = ROW_W'(ROW_COUNT - 1) - row_lin;

    always_comb begin
        o_res.kind = KIND_HIT;
        o_res.row  = row_lin;
        o_res.col  = col_lin;
        if (past_end) begin
            o_res.kind = KIND_OVERFLOW;
            o_res.row  = '0;
            o_res.col  = '0;
        end else begin
            unique case (col_lin[1:0])
                2'd0: begin
                    o_res.row = row_lin;
                    o_res.col = col_lin;
                end
                2'd1: begin
                    o_res.row = row_mir;
                    o_res.col = col_lin;
                end
                2'd2: begin
                    o_res.row = row_lin;
                    o_res.col = col_lin + COL_W'(1);
                end
                default: begin
                    o_res.row = row_mir;
                    o_res.col = col_lin - COL_W'(1);
                end
            endcase
        end
    end

endmodule

/* rtl/core/hwd_merge.sv */
// result buffer of all lanes and the stage that sends them out one per cycle while the output is not stalled
module hwd_merge (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_load,
    input  hwd_pkg::t_load                            i_load_info,
    input  hwd_pkg::t_lane_res [hwd_pkg::HITS_PER_WORD-1:0] i_lanes,
    output logic                                      o_load_ready,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output hwd_pkg::t_lane_res                        o_res,
    output logic [hwd_pkg::FC_W-1:0]                  o_fc,
    output logic [hwd_pkg::TRIG_W-1:0]                o_trig,
    output logic                                      o_last
);
    import hwd_pkg::*;

    logic [HITS_PER_WORD-1:0] r_mask, n_mask;
    t_lane_res                r_ent [HITS_PER_WORD];
    logic [FC_W-1:0]          r_fc;
    logic [TRIG_W-1:0]        r_trig;

    logic                     r_out_valid, n_out_valid;
    t_lane_res                r_out_res;
    logic [FC_W-1:0]          r_out_fc;
    logic [TRIG_W-1:0]        r_out_trig;
    logic                     r_out_last;

    logic                     out_free;
    logic                     take;
    logic [LANE_W-1:0]        pick;
    logic [HITS_PER_WORD-1:0] rest;

    // lowest pending slot goes first
    always_comb begin
        pick = '0;
        for (int i = HITS_PER_WORD - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick = LANE_W'(i);
            end
        end
    end

    assign out_free     = !r_out_valid || i_ready;
    assign take         = out_free && (r_mask != '0);
    assign rest         = r_mask & ~(HITS_PER_WORD'(1) << pick);
    assign o_load_ready = (r_mask == '0) || (take && (rest == '0));

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_load_info.mask;
        end else if (take) begin
            n_mask = rest;
        end
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < HITS_PER_WORD; i++) begin
                r_ent[i] <= i_lanes[i];
            end
            r_fc   <= i_load_info.fc;
            r_trig <= i_load_info.trig;
        end
        if (take) begin
            r_out_res  <= r_ent[pick];
            r_out_fc   <= r_fc;
            r_out_trig <= r_trig;
            r_out_last <= (rest == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;
    assign o_fc    = r_out_fc;
    assign o_trig  = r_out_trig;
    assign o_last  = r_out_last;

endmodule
